// ===== hdl/gsit_pkg.sv =====
// Package for the grouped sorted index table.
// Holds default sizes, the fixed field widths, the datapath operation codes and
// the controller/datapath status struct. No dependencies.
`default_nettype none

package gsit_pkg;

    // Default sizes handed to the top level parameters.
    localparam int MAX_GROUPS_DEF  = 64;
    localparam int MAX_MEMBERS_DEF = 16;
    localparam int NUM_MODES_DEF   = 4;
    localparam int MODE_BITS_DEF   = 8;

    // Fixed field widths of the item layouts.
    localparam int VIB_W    = 32;
    localparam int FULL_W   = 20;
    localparam int MONO_W   = 16;
    localparam int STATUS_W = 2;
    localparam int GPOS_W   = 6;
    localparam int MPOS_W   = 4;
    localparam int TOTAL_W  = 7;
    localparam int S_TDATA_W = 72;
    localparam int M_TDATA_W = 24;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_ADDED = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NEW   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_DUP   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd3;

    // Datapath operations issued by the controller.
    typedef logic [4:0] op_t;
    localparam op_t OP_NONE   = 5'd0;
    localparam op_t OP_LOAD   = 5'd1;
    localparam op_t OP_GS_RD  = 5'd2;
    localparam op_t OP_GS_UPD = 5'd3;
    localparam op_t OP_GF_RD  = 5'd4;
    localparam op_t OP_GF_CHK = 5'd5;
    localparam op_t OP_CN_LD  = 5'd6;
    localparam op_t OP_MS_RD  = 5'd7;
    localparam op_t OP_MS_UPD = 5'd8;
    localparam op_t OP_MD_RD  = 5'd9;
    localparam op_t OP_MD_CHK = 5'd10;
    localparam op_t OP_MSH_RD = 5'd11;
    localparam op_t OP_MSH_WR = 5'd12;
    localparam op_t OP_MINS   = 5'd13;
    localparam op_t OP_GSH_RD = 5'd14;
    localparam op_t OP_GSH_WR = 5'd15;
    localparam op_t OP_GINS   = 5'd16;
    localparam op_t OP_FIN    = 5'd17;

    typedef struct packed {
        op_t op;
    } cmd_t;

    typedef struct packed {
        logic g_more;    // group search range not empty
        logic found;     // key held at the lower-bound position
        logic tbl_full;  // all groups in use
        logic g_shift;   // group entries still to move up
        logic m_more;    // member search range not empty
        logic m_stop;    // duplicate index or full group
        logic m_shift;   // member entries still to move up
        logic out_free;  // output register can take a result
    } stat_t;

endpackage

`default_nettype wire

// ===== hdl/gsit_ctrl.sv =====
// Controller state machine for the grouped sorted index table.
// Sequences the datapath through search, shift and insert. Uses gsit_pkg.
`default_nettype none

module gsit_ctrl (
    input  wire             aclk,
    input  wire             aresetn,
    input  wire             s_tvalid,
    output logic            s_tready,
    input  gsit_pkg::stat_t stat,
    output gsit_pkg::cmd_t  cmd
);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_GS_CHK  = 4'd1;
    localparam logic [3:0] S_GS_WAIT = 4'd2;
    localparam logic [3:0] S_GF_CHK  = 4'd3;
    localparam logic [3:0] S_CN_LD   = 4'd4;
    localparam logic [3:0] S_MS_CHK  = 4'd5;
    localparam logic [3:0] S_MS_WAIT = 4'd6;
    localparam logic [3:0] S_MD_CHK  = 4'd7;
    localparam logic [3:0] S_MSH_CHK = 4'd8;
    localparam logic [3:0] S_MSH_WR  = 4'd9;
    localparam logic [3:0] S_GSH_CHK = 4'd10;
    localparam logic [3:0] S_GSH_WR  = 4'd11;
    localparam logic [3:0] S_FIN     = 4'd12;

    logic [3:0] state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // No item is taken while reset is held.
    assign s_tready = aresetn && (state_reg == S_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd.op     = gsit_pkg::OP_NONE;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid && s_tready) begin
                    cmd.op     = gsit_pkg::OP_LOAD;
                    state_next = S_GS_CHK;
                end
            end
            S_GS_CHK: begin
                if (stat.g_more) begin
                    cmd.op     = gsit_pkg::OP_GS_RD;
                    state_next = S_GS_WAIT;
                end else begin
                    cmd.op     = gsit_pkg::OP_GF_RD;
                    state_next = S_GF_CHK;
                end
            end
            S_GS_WAIT: begin
                cmd.op     = gsit_pkg::OP_GS_UPD;
                state_next = S_GS_CHK;
            end
            S_GF_CHK: begin
                cmd.op = gsit_pkg::OP_GF_CHK;
                if (stat.found) begin
                    state_next = S_CN_LD;
                end else if (stat.tbl_full) begin
                    state_next = S_FIN;
                end else begin
                    state_next = S_GSH_CHK;
                end
            end
            S_CN_LD: begin
                cmd.op     = gsit_pkg::OP_CN_LD;
                state_next = S_MS_CHK;
            end
            S_MS_CHK: begin
                if (stat.m_more) begin
                    cmd.op     = gsit_pkg::OP_MS_RD;
                    state_next = S_MS_WAIT;
                end else begin
                    cmd.op     = gsit_pkg::OP_MD_RD;
                    state_next = S_MD_CHK;
                end
            end
            S_MS_WAIT: begin
                cmd.op     = gsit_pkg::OP_MS_UPD;
                state_next = S_MS_CHK;
            end
            S_MD_CHK: begin
                cmd.op     = gsit_pkg::OP_MD_CHK;
                state_next = stat.m_stop ? S_FIN : S_MSH_CHK;
            end
            S_MSH_CHK: begin
                if (stat.m_shift) begin
                    cmd.op     = gsit_pkg::OP_MSH_RD;
                    state_next = S_MSH_WR;
                end else begin
                    cmd.op     = gsit_pkg::OP_MINS;
                    state_next = S_FIN;
                end
            end
            S_MSH_WR: begin
                cmd.op     = gsit_pkg::OP_MSH_WR;
                state_next = S_MSH_CHK;
            end
            S_GSH_CHK: begin
                if (stat.g_shift) begin
                    cmd.op     = gsit_pkg::OP_GSH_RD;
                    state_next = S_GSH_WR;
                end else begin
                    cmd.op     = gsit_pkg::OP_GINS;
                    state_next = S_FIN;
                end
            end
            S_GSH_WR: begin
                cmd.op     = gsit_pkg::OP_GSH_WR;
                state_next = S_GSH_CHK;
            end
            S_FIN: begin
                if (stat.out_free) begin
                    cmd.op     = gsit_pkg::OP_FIN;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== hdl/gsit_dpath.sv =====
// Datapath for the grouped sorted index table: key, slot, count and member
// memories, search bounds, shift counters and the output register. Uses gsit_pkg.
`default_nettype none

module gsit_dpath #(
    parameter int MAX_GROUPS  = gsit_pkg::MAX_GROUPS_DEF,
    parameter int MAX_MEMBERS = gsit_pkg::MAX_MEMBERS_DEF,
    parameter int NUM_MODES   = gsit_pkg::NUM_MODES_DEF,
    parameter int MODE_BITS   = gsit_pkg::MODE_BITS_DEF
) (
    input  wire                                aclk,
    input  wire                                aresetn,
    input  gsit_pkg::cmd_t                     cmd,
    output gsit_pkg::stat_t                    stat,
    input  wire  [gsit_pkg::S_TDATA_W-1:0]     s_tdata,
    output logic                               m_tvalid,
    input  wire                                m_tready,
    output logic [gsit_pkg::M_TDATA_W-1:0]     m_tdata
);

    localparam int KBITS = NUM_MODES * MODE_BITS;
    localparam int KMW   = (KBITS < gsit_pkg::VIB_W) ? KBITS : gsit_pkg::VIB_W;
    localparam int KW    = KMW + 1;
    localparam int GW    = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
    localparam int GCW   = $clog2(MAX_GROUPS + 1);
    localparam int MCW   = $clog2(MAX_MEMBERS + 1);
    localparam int DEPTH = MAX_GROUPS * MAX_MEMBERS;
    localparam int AW    = $clog2(DEPTH);
    localparam int FW    = gsit_pkg::FULL_W;
    localparam int MNW   = gsit_pkg::MONO_W;
    localparam int SW    = gsit_pkg::STATUS_W;
    localparam int GPW   = gsit_pkg::GPOS_W;
    localparam int MPW   = gsit_pkg::MPOS_W;
    localparam int TW    = gsit_pkg::TOTAL_W;

    // Memories.
    logic [KW-1:0]  key_mem  [MAX_GROUPS];
    logic [GW-1:0]  slot_mem [MAX_GROUPS];
    logic [MCW-1:0] cnt_mem  [MAX_GROUPS];
    logic [MNW-1:0] mon_mem  [DEPTH];
    logic [FW-1:0]  full_mem [DEPTH];

    logic [KW-1:0]  key_q;
    logic [GW-1:0]  slot_q;
    logic [MCW-1:0] cnt_q;
    logic [MNW-1:0] mon_q;
    logic [FW-1:0]  full_q;

    // Request and working registers.
    logic [KW-1:0]  key_reg;
    logic [FW-1:0]  fidx_reg;
    logic [MNW-1:0] midx_reg;
    logic [GCW-1:0] n_reg, glo_reg, ghi_reg, gi_reg;
    logic [GW-1:0]  slot_reg;
    logic [MCW-1:0] cnt_reg, mlo_reg, mhi_reg, mi_reg;
    logic [SW-1:0]  res_status_reg;
    logic [MCW-1:0] res_mpos_reg;
    logic           m_tvalid_reg;
    logic [gsit_pkg::M_TDATA_W-1:0] m_tdata_reg;

    logic [GCW-1:0] gmid, gi_dec;
    logic [MCW-1:0] mmid, mi_dec, cnt_sat;
    logic           dup;

    function automatic logic [AW-1:0] maddr(input logic [GW-1:0] s, input logic [MCW-1:0] i);
        maddr = AW'(s) * AW'(MAX_MEMBERS) + AW'(i);
    endfunction

    assign gmid    = glo_reg + ((ghi_reg - glo_reg) >> 1);
    assign mmid    = mlo_reg + ((mhi_reg - mlo_reg) >> 1);
    assign gi_dec  = gi_reg - 1'b1;
    assign mi_dec  = mi_reg - 1'b1;
    assign cnt_sat = (cnt_q > MCW'(MAX_MEMBERS)) ? MCW'(MAX_MEMBERS) : cnt_q;
    assign dup     = (mlo_reg < cnt_reg) && (mon_q == midx_reg);

    assign stat.g_more   = glo_reg < ghi_reg;
    assign stat.found    = (glo_reg < n_reg) && (key_q == key_reg);
    assign stat.tbl_full = n_reg >= GCW'(MAX_GROUPS);
    assign stat.g_shift  = gi_reg > glo_reg;
    assign stat.m_more   = mlo_reg < mhi_reg;
    assign stat.m_stop   = dup || (cnt_reg >= MCW'(MAX_MEMBERS));
    assign stat.m_shift  = mi_reg > mlo_reg;
    assign stat.out_free = !m_tvalid_reg || m_tready;

    // Read addresses.
    logic [GW-1:0] g_raddr, c_raddr;
    logic [AW-1:0] m_raddr;

    always_comb begin
        case (cmd.op)
            gsit_pkg::OP_GS_RD:  g_raddr = gmid[GW-1:0];
            gsit_pkg::OP_GSH_RD: g_raddr = gi_dec[GW-1:0];
            default:             g_raddr = glo_reg[GW-1:0];
        endcase
        c_raddr = slot_q;
        case (cmd.op)
            gsit_pkg::OP_MS_RD:  m_raddr = maddr(slot_reg, mmid);
            gsit_pkg::OP_MSH_RD: m_raddr = maddr(slot_reg, mi_dec);
            default:             m_raddr = maddr(slot_reg, mlo_reg);
        endcase
    end

    always_ff @(posedge aclk) begin
        key_q  <= key_mem[g_raddr];
        slot_q <= slot_mem[g_raddr];
        cnt_q  <= cnt_mem[c_raddr];
        mon_q  <= mon_mem[m_raddr];
        full_q <= full_mem[m_raddr];
    end

    // Memory writes.
    always_ff @(posedge aclk) begin
        case (cmd.op)
            gsit_pkg::OP_GSH_WR: begin
                key_mem[gi_reg[GW-1:0]]  <= key_q;
                slot_mem[gi_reg[GW-1:0]] <= slot_q;
            end
            gsit_pkg::OP_GINS: begin
                key_mem[glo_reg[GW-1:0]]        <= key_reg;
                slot_mem[glo_reg[GW-1:0]]       <= n_reg[GW-1:0];
                cnt_mem[n_reg[GW-1:0]]          <= MCW'(1);
                mon_mem[maddr(n_reg[GW-1:0], '0)]  <= midx_reg;
                full_mem[maddr(n_reg[GW-1:0], '0)] <= fidx_reg;
            end
            gsit_pkg::OP_MSH_WR: begin
                mon_mem[maddr(slot_reg, mi_reg)]  <= mon_q;
                full_mem[maddr(slot_reg, mi_reg)] <= full_q;
            end
            gsit_pkg::OP_MINS: begin
                mon_mem[maddr(slot_reg, mlo_reg)]  <= midx_reg;
                full_mem[maddr(slot_reg, mlo_reg)] <= fidx_reg;
                cnt_mem[slot_reg]                  <= cnt_reg + 1'b1;
            end
            default: begin
            end
        endcase
    end

    // Working registers.
    always_ff @(posedge aclk) begin
        case (cmd.op)
            gsit_pkg::OP_LOAD: begin
                key_reg  <= {s_tdata[KMW:1], s_tdata[0]};
                fidx_reg <= s_tdata[52:33];
                midx_reg <= s_tdata[68:53];
                glo_reg  <= '0;
                ghi_reg  <= n_reg;
            end
            gsit_pkg::OP_GS_UPD: begin
                if (key_q < key_reg) begin
                    glo_reg <= gmid + 1'b1;
                end else begin
                    ghi_reg <= gmid;
                end
            end
            gsit_pkg::OP_GF_CHK: begin
                slot_reg       <= slot_q;
                gi_reg         <= n_reg;
                res_status_reg <= gsit_pkg::ST_FULL;
                res_mpos_reg   <= '0;
            end
            gsit_pkg::OP_CN_LD: begin
                cnt_reg <= cnt_sat;
                mlo_reg <= '0;
                mhi_reg <= cnt_sat;
            end
            gsit_pkg::OP_MS_UPD: begin
                if (mon_q < midx_reg) begin
                    mlo_reg <= mmid + 1'b1;
                end else begin
                    mhi_reg <= mmid;
                end
            end
            gsit_pkg::OP_MD_CHK: begin
                mi_reg <= cnt_reg;
                if (dup) begin
                    res_status_reg <= gsit_pkg::ST_DUP;
                    res_mpos_reg   <= mlo_reg;
                end else begin
                    res_status_reg <= gsit_pkg::ST_FULL;
                    res_mpos_reg   <= '0;
                end
            end
            gsit_pkg::OP_MSH_WR: mi_reg <= mi_dec;
            gsit_pkg::OP_GSH_WR: gi_reg <= gi_dec;
            gsit_pkg::OP_MINS: begin
                res_status_reg <= gsit_pkg::ST_ADDED;
                res_mpos_reg   <= mlo_reg;
            end
            gsit_pkg::OP_GINS: begin
                res_status_reg <= gsit_pkg::ST_NEW;
                res_mpos_reg   <= '0;
            end
            default: begin
            end
        endcase
    end

    // Group count and output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            n_reg        <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cmd.op == gsit_pkg::OP_GINS) begin
                n_reg <= n_reg + 1'b1;
            end
            if (cmd.op == gsit_pkg::OP_FIN) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.op == gsit_pkg::OP_FIN) begin
            m_tdata_reg <= {5'd0, TW'(n_reg), MPW'(res_mpos_reg), GPW'(glo_reg),
                            res_status_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        n_reg <= GCW'(MAX_GROUPS))
        else $error("group count above table size");

    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == gsit_pkg::OP_GINS) |=> (n_reg == $past(n_reg) + 1'b1))
        else $error("group count did not advance on a new group");

    a_count_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op != gsit_pkg::OP_GINS) |=> $stable(n_reg))
        else $error("group count changed without a new group");

endmodule

`default_nettype wire

// ===== hdl/grouped_sorted_index_table.sv =====
// Top level of the grouped sorted index table.
// Joins the controller (gsit_ctrl) and the datapath (gsit_dpath); uses gsit_pkg.
//
//   channel   direction  handshake            payload
//   s_        in         s_tvalid / s_tready  s_tdata: one insert request item
//   m_        out        m_tvalid / m_tready  m_tdata: one result item
//
// Each item starts with a lower-bound binary search over the group keys, one
// probe at a time on the registered key memory, up to floor(log2(groups held))+1
// probes. A found group then takes a member search, one probe at a time, and,
// unless the index is already held or the group is full, a shift of its sorted
// pairs, one pair at a time. A new group shifts the sorted group entries instead;
// a full table moves nothing and gives the full status.
// Reset (aresetn, synchronous, active low) empties the table by clearing the group
// count; the memories need no clearing pass. A result held on a stalled m_ side
// does not block the next request; the block only waits when it must hand over
// a second result.
`default_nettype none

module grouped_sorted_index_table #(
    parameter int MAX_GROUPS  = gsit_pkg::MAX_GROUPS_DEF,
    parameter int MAX_MEMBERS = gsit_pkg::MAX_MEMBERS_DEF,
    parameter int NUM_MODES   = gsit_pkg::NUM_MODES_DEF,
    parameter int MODE_BITS   = gsit_pkg::MODE_BITS_DEF
) (
    input  wire                             aclk,
    input  wire                             aresetn,
    input  wire                             s_tvalid,
    output logic                            s_tready,
    // s_tdata from bit 0: exc_surface[0], vib_modes[32:1], full_index[52:33],
    // monomer_index[68:53], zero fill [71:69].
    input  wire  [gsit_pkg::S_TDATA_W-1:0]  s_tdata,
    output logic                            m_tvalid,
    input  wire                             m_tready,
    // m_tdata from bit 0: status[1:0], group_position[7:2], member_position[11:8],
    // group_total[18:12], zero fill [23:19].
    output logic [gsit_pkg::M_TDATA_W-1:0]  m_tdata
);

    gsit_pkg::cmd_t  cmd;
    gsit_pkg::stat_t stat;

    // The controller owns the input handshake and the step sequence.
    gsit_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // The datapath holds the table and the output register.
    gsit_dpath #(
        .MAX_GROUPS  (MAX_GROUPS),
        .MAX_MEMBERS (MAX_MEMBERS),
        .NUM_MODES   (NUM_MODES),
        .MODE_BITS   (MODE_BITS)
    ) u_dpath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .stat     (stat),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

`default_nettype wire

// ===== sim/tb_grouped_sorted_index_table.sv =====
// Self-checking testbench for grouped_sorted_index_table: insert requests go in,
// and each result item is checked against a behavioral table model kept here.
// Depends on gsit_pkg and the grouped_sorted_index_table RTL.
`timescale 1ns / 100ps

module tb_grouped_sorted_index_table;

    localparam int GROUPS  = gsit_pkg::MAX_GROUPS_DEF;
    localparam int MEMBERS = gsit_pkg::MAX_MEMBERS_DEF;
    localparam int CYCLE_LIMIT = 3000000;
    localparam int SETTLE_CYCLES = 300;

    // The result item, laid out as it sits in the low bits of m_tdata.
    typedef struct packed {
        logic [gsit_pkg::TOTAL_W-1:0]  total;
        logic [gsit_pkg::MPOS_W-1:0]   mpos;
        logic [gsit_pkg::GPOS_W-1:0]   gpos;
        logic [gsit_pkg::STATUS_W-1:0] status;
    } result_t;

    logic                           aclk = 1'b0;
    logic                           aresetn = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [gsit_pkg::S_TDATA_W-1:0] s_tdata = '0;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [gsit_pkg::M_TDATA_W-1:0] m_tdata;

    grouped_sorted_index_table uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    // Shadow of the table contents. Keys and slot numbers are kept per sorted
    // position; member counts and monomer indices per physical slot.
    logic [32:0] key_by_pos[GROUPS];
    int          slot_by_pos[GROUPS];
    int          fill_by_slot[GROUPS];
    logic [15:0] mono_by_slot[GROUPS][MEMBERS];
    int          groups_held = 0;

    result_t pending_results[$];
    int      error_count = 0;
    int      cycle_count = 0;
    int      burst_left = 0;
    bit      hold_off_req = 1'b0;

    // Pools of keys and monomer indices, so that groups get hit again and
    // duplicates and full groups come up often.
    logic [32:0] key_pool[48];
    logic [15:0] mono_pool[24];

    // Works out the result of one insert request and updates the shadow table.
    function automatic result_t insert_pair(logic exc, logic [31:0] vib, logic [15:0] mono);
        result_t     res;
        logic [32:0] key;
        int          lo, hi, mid, slot, cnt;
        key = {vib, exc};
        lo = 0;
        hi = groups_held;
        while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            if (key_by_pos[mid] < key) lo = mid + 1;
            else hi = mid;
        end
        res.gpos = lo[gsit_pkg::GPOS_W-1:0];
        res.mpos = '0;
        if (lo < groups_held && key_by_pos[lo] == key) begin
            slot = slot_by_pos[lo];
            cnt = fill_by_slot[slot];
            lo = 0;
            hi = cnt;
            while (lo < hi) begin
                mid = lo + (hi - lo) / 2;
                if (mono_by_slot[slot][mid] < mono) lo = mid + 1;
                else hi = mid;
            end
            if (lo < cnt && mono_by_slot[slot][lo] == mono) begin
                // The index is already held: nothing changes.
                res.status = gsit_pkg::ST_DUP;
                res.mpos = lo[gsit_pkg::MPOS_W-1:0];
            end else if (cnt >= MEMBERS) begin
                res.status = gsit_pkg::ST_FULL;
            end else begin
                for (int i = cnt; i > lo; i--) mono_by_slot[slot][i] = mono_by_slot[slot][i-1];
                mono_by_slot[slot][lo] = mono;
                fill_by_slot[slot] = cnt + 1;
                res.status = gsit_pkg::ST_ADDED;
                res.mpos = lo[gsit_pkg::MPOS_W-1:0];
            end
        end else if (groups_held >= GROUPS) begin
            res.status = gsit_pkg::ST_FULL;
        end else begin
            // A new group takes the next unused physical slot.
            for (int i = groups_held; i > lo; i--) begin
                key_by_pos[i] = key_by_pos[i-1];
                slot_by_pos[i] = slot_by_pos[i-1];
            end
            key_by_pos[lo] = key;
            slot_by_pos[lo] = groups_held;
            mono_by_slot[groups_held][0] = mono;
            fill_by_slot[groups_held] = 1;
            groups_held++;
            res.status = gsit_pkg::ST_NEW;
        end
        res.total = groups_held[gsit_pkg::TOTAL_W-1:0];
        return res;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        error_count++;
        if (error_count <= 40)
            $display("[%0t] %s: got %0d, expected %0d", $time, what, got, want);
    endtask

    // Offers one item and waits until it is taken. Between bursts the sender
    // sometimes drops tvalid for a random gap.
    task automatic send_item(logic exc, logic [31:0] vib, logic [19:0] fidx, logic [15:0] mono);
        s_tvalid <= 1'b1;
        s_tdata <= {3'b000, mono, fidx, vib, exc};
        forever begin
            @(posedge aclk);
            if (s_tready) break;
        end
        pending_results = {pending_results, insert_pair(exc, vib, mono)};
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 3) == 0 ? 200 : $urandom_range(1, 12);
            if ($urandom_range(0, 1)) begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 20)) @(posedge aclk);
            end
        end
    endtask

    // Stops sending until every expected result has been taken.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Smallest and largest keys and indices, and a key that differs from the
    // smallest only in the exciton bit.
    task automatic test_key_extremes();
        send_item(1'b0, 32'h0000_0000, 20'h00000, 16'h0000);
        send_item(1'b1, 32'hFFFF_FFFF, 20'hFFFFF, 16'hFFFF);
        send_item(1'b0, 32'h0000_0000, 20'hFFFFF, 16'hFFFF);
        send_item(1'b1, 32'h0000_0000, 20'h12345, 16'h8000);
        send_item(1'b0, 32'h8000_0001, 20'h54321, 16'h7FFF);
        send_item(1'b0, 32'hFFFF_FFFF, 20'h00001, 16'h0001);
    endtask

    // A repeated monomer index within a group is refused.
    task automatic test_duplicate_index();
        send_item(1'b0, 32'h0000_0000, 20'h0ABCD, 16'h0000);
        send_item(1'b1, 32'hFFFF_FFFF, 20'h00000, 16'hFFFF);
    endtask

    // Fills one group in descending order, so each pair goes to the front, then
    // offers one more new index and one that is already held.
    task automatic test_full_group();
        for (int i = MEMBERS; i > 0; i--)
            send_item(1'b1, 32'h1234_5678, 20'($urandom_range(0, 20'hFFFFF)), 16'(i * 100));
        send_item(1'b1, 32'h1234_5678, 20'h00000, 16'd50);
        send_item(1'b1, 32'h1234_5678, 20'h00000, 16'd800);
    endtask

    // Mostly keys from the pool with random content, and some fresh keys that
    // fill the table until new groups are refused.
    task automatic test_random_inserts(int count);
        logic [32:0] key;
        logic [15:0] mono;
        for (int n = 0; n < count; n++) begin
            if (n == count / 3) hold_off_req = 1'b1;
            if (n == 2 * count / 3) drain_results();
            if ($urandom_range(0, 9) < 7) key = key_pool[$urandom_range(0, 47)];
            else key = {$urandom, 1'($urandom)};
            mono = $urandom_range(0, 9) < 6 ? mono_pool[$urandom_range(0, 23)]
                                            : 16'($urandom);
            send_item(key[0], key[32:1], 20'($urandom), mono);
        end
    endtask

    initial begin
        foreach (key_pool[i]) key_pool[i] = {$urandom, 1'($urandom)};
        key_pool[0] = '0;
        key_pool[1] = '1;
        foreach (mono_pool[i]) mono_pool[i] = 16'($urandom);
        mono_pool[0] = 16'h0000;
        mono_pool[1] = 16'hFFFF;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_key_extremes();
        test_duplicate_index();
        test_full_group();
        drain_results();
        test_random_inserts(1800);
        drain_results();
        if (error_count == 0 && pending_results.size() == 0) begin
            $display("grouped_sorted_index_table: match");
        end else begin
            $display("grouped_sorted_index_table: mismatch");
        end
        $finish;
    end

    // Receiver: changes its stall style every so often, including stretches
    // with no stalls, and on request holds off long enough to back up the block.
    initial begin
        int style;
        forever begin
            if (hold_off_req) begin
                m_tready <= 1'b0;
                repeat (600) @(posedge aclk);
                hold_off_req = 1'b0;
            end else begin
                style = $urandom_range(0, 2);
                repeat ($urandom_range(20, 150)) begin
                    case (style)
                        0: m_tready <= 1'b1;
                        1: m_tready <= 1'($urandom);
                        default: m_tready <= ($urandom_range(0, 7) != 0);
                    endcase
                    @(posedge aclk);
                end
            end
        end
    end

    // Checks each result item as it is taken, and guards the run length.
    always @(posedge aclk) begin
        result_t got, want;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("grouped_sorted_index_table: mismatch");
            $finish;
        end
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[18:0];
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result, status", got.status, 0);
            end else begin
                want = pending_results.pop_front();
                if (got.status != want.status) report_mismatch("status", got.status, want.status);
                if (got.gpos != want.gpos) report_mismatch("group_position", got.gpos, want.gpos);
                if (got.mpos != want.mpos) report_mismatch("member_position", got.mpos, want.mpos);
                if (got.total != want.total) report_mismatch("group_total", got.total, want.total);
            end
        end
    end

endmodule
